// ----- rtl/core/gcvm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcvm_pkg: shared types and constants for the gradient vote map
// Map geometry, request codes, transfer payloads and sequencer states.
// ----------------------------------------------------------------------------
package gcvm_pkg;

  localparam int MAP_WIDTH  = 64;
  localparam int MAP_HEIGHT = 64;
  localparam int COORD_W    = 6;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int MAP_DEPTH  = MAP_WIDTH * MAP_HEIGHT;
  localparam int SIZE_W     = 7;
  localparam int SUM_W      = 32;
  localparam int NUM_W      = 30;   // dot^2 >> 14 never exceeds 30 bits
  localparam int DEN_W      = 13;   // dx^2 + dy^2 <= 2*63^2

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd50;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2,
    OP_MAX   = 2'd3
  } op_t;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] vote_value;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic        saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_A_MUL1,
    ST_A_MUL2,
    ST_A_SQ,
    ST_A_DST,
    ST_A_DIV,
    ST_A_WR,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_M_ADDR,
    ST_M_CMP,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/gcvm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcvm_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gcvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/gcvm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcvm_div: restoring divider, one quotient bit per cycle
// Unsigned NUM_W / DEN_W; done pulses high for a single cycle, set together with the last quotient bit.
// ----------------------------------------------------------------------------
module gcvm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gcvm_pkg::NUM_W-1:0] num,
  input  logic [gcvm_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [gcvm_pkg::NUM_W-1:0] quo
);
  import gcvm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      rem_nxt  = '0;
      den_nxt  = den;
      q_nxt    = num;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_nxt   = {q_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- rtl/core/gradient_center_vote_map_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_center_vote_map_top: means-of-gradients eye center vote map
// Holds a 64x64 map of Q16.16 vote sums and serves clear, accumulate,
// read and find-max requests, one at a time, one result per request.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-entry map to zero (in_ready
// low). A clear also sweeps the whole map. An accumulate visits each
// active cell in turn; a cell passes through the multiply, square and
// write steps, and through the bit-serial divider only when its dot
// product is positive. Read addresses the map and then takes the data;
// find-max reads and compares each active cell in turn. Each request
// ends with one result transfer on the out_ channel; the output register
// lets a new request be taken while the previous result waits.
// Configuration (active columns and rows, index 0 and 1) must be written
// only while idle; the block does not enforce this. 0 acts as 1 and
// values above 64 act as 64.
// ----------------------------------------------------------------------------
module gradient_center_vote_map_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  gcvm_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output gcvm_pkg::out_item_t       out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gcvm_pkg::SIZE_W-1:0] cfg_wdata
);
  import gcvm_pkg::*;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  cols_cfg_r, rows_cfg_r;
  logic [SIZE_W-1:0]  cols, rows;
  logic [COORD_W-1:0] cols_m1, rows_m1;

  logic [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [15:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic signed [22:0] p1_r, p1_nxt;
  logic signed [23:0] dot_r, dot_nxt;
  logic [DEN_W-1:0]   d2_r, d2_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [NUM_W-1:0]   q_r, q_nxt;
  logic [SUM_W-1:0]   best_r, best_nxt;
  logic [COORD_W-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic               sat_r, sat_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // RAM / divider hookup
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [SUM_W-1:0]  ram_wdata, ram_rdata;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_quo;

  // per-cell arithmetic
  logic signed [6:0] dx, dy;
  logic [5:0]        dxa, dya;
  logic [45:0]       sq;
  logic [SUM_W:0]    sum;
  logic              last_x, last_y, own_cell, dot_pos, in_area;
  logic              accept, out_free;

  assign cols    = (cols_cfg_r == '0) ? SIZE_W'(1)
                 : (cols_cfg_r > SIZE_W'(MAP_WIDTH)) ? SIZE_W'(MAP_WIDTH) : cols_cfg_r;
  assign rows    = (rows_cfg_r == '0) ? SIZE_W'(1)
                 : (rows_cfg_r > SIZE_W'(MAP_HEIGHT)) ? SIZE_W'(MAP_HEIGHT) : rows_cfg_r;
  assign cols_m1 = COORD_W'(cols - 1'b1);
  assign rows_m1 = COORD_W'(rows - 1'b1);

  assign dx  = $signed({1'b0, px_r}) - $signed({1'b0, cx_r});
  assign dy  = $signed({1'b0, py_r}) - $signed({1'b0, cy_r});
  assign dxa = dx[6] ? 6'(-dx) : dx[5:0];
  assign dya = dy[6] ? 6'(-dy) : dy[5:0];
  assign sq  = 46'(dot_r[22:0]) * 46'(dot_r[22:0]);
  assign sum = {1'b0, ram_rdata} + (SUM_W + 1)'(q_r);

  assign last_x   = (cx_r == cols_m1);
  assign last_y   = (cy_r == rows_m1);
  assign own_cell = (cx_r == px_r) && (cy_r == py_r);
  assign dot_pos  = !dot_r[23] && (dot_r != '0);
  assign in_area  = ({1'b0, px_r} < cols) && ({1'b0, py_r} < rows);

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign ram_raddr = (state_r == ST_RD_ADDR) ? {py_r, px_r} : {cy_r, cx_r};
  assign ram_waddr = {cy_r, cx_r};
  assign div_start = (state_r == ST_A_DST) && dot_pos;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT, ST_CLR: begin
        if (cx_r == '1 && cy_r == '1) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_data.opcode))
            OP_CLEAR: state_nxt = ST_CLR;
            OP_ACCUM: state_nxt = ST_A_MUL1;
            OP_READ:  state_nxt = ST_RD_ADDR;
            OP_MAX:   state_nxt = ST_M_ADDR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_A_MUL1: begin
        if (own_cell) begin
          state_nxt = (last_x && last_y) ? ST_DONE : ST_A_MUL1;
        end else begin
          state_nxt = ST_A_MUL2;
        end
      end
      ST_A_MUL2: state_nxt = ST_A_SQ;
      ST_A_SQ:   state_nxt = ST_A_DST;
      ST_A_DST:  state_nxt = dot_pos ? ST_A_DIV : ST_A_WR;
      ST_A_DIV:  state_nxt = div_done ? ST_A_WR : ST_A_DIV;
      ST_A_WR:   state_nxt = (last_x && last_y) ? ST_DONE : ST_A_MUL1;
      ST_RD_ADDR: state_nxt = ST_RD_DATA;
      ST_RD_DATA: state_nxt = ST_DONE;
      ST_M_ADDR:  state_nxt = ST_M_CMP;
      ST_M_CMP:   state_nxt = (last_x && last_y) ? ST_DONE : ST_M_ADDR;
      ST_DONE:    state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    p1_nxt        = p1_r;
    dot_nxt       = dot_r;
    d2_nxt        = d2_r;
    num_nxt       = num_r;
    q_nxt         = q_r;
    best_nxt      = best_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_wdata     = '0;

    case (state_r)
      ST_INIT, ST_CLR: begin
        // full-map sweep regardless of active size
        ram_we  = 1'b1;
        sat_nxt = 1'b0;
        cx_nxt  = cx_r + 1'b1;
        if (cx_r == '1) begin
          cy_nxt = cy_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          px_nxt   = in_data.pos_x;
          py_nxt   = in_data.pos_y;
          gx_nxt   = in_data.grad_x;
          gy_nxt   = in_data.grad_y;
          cx_nxt   = '0;
          cy_nxt   = '0;
          best_nxt = '0;
          bx_nxt   = '0;
          by_nxt   = '0;
          if (op_t'(in_data.opcode) == OP_READ) begin
            bx_nxt = in_data.pos_x;
            by_nxt = in_data.pos_y;
          end
        end
      end
      ST_A_MUL1: begin
        p1_nxt = dx * gx_r;
        d2_nxt = DEN_W'(dxa) * DEN_W'(dxa) + DEN_W'(dya) * DEN_W'(dya);
        if (own_cell) begin
          cx_nxt = last_x ? '0 : cx_r + 1'b1;
          if (last_x) begin
            cy_nxt = cy_r + 1'b1;
          end
        end
      end
      ST_A_MUL2: dot_nxt = 24'(p1_r) + 24'(dy) * 24'(gy_r);
      ST_A_SQ:   num_nxt = sq[43:14];
      ST_A_DST:  q_nxt = '0;
      ST_A_DIV: begin
        if (div_done) begin
          q_nxt = div_quo;
        end
      end
      ST_A_WR: begin
        ram_we = 1'b1;
        if (sum[SUM_W]) begin
          ram_wdata = '1;
          sat_nxt   = 1'b1;
        end else begin
          ram_wdata = sum[SUM_W-1:0];
        end
        cx_nxt = last_x ? '0 : cx_r + 1'b1;
        if (last_x) begin
          cy_nxt = cy_r + 1'b1;
        end
      end
      ST_RD_DATA: best_nxt = in_area ? ram_rdata : '0;
      ST_M_CMP: begin
        if (ram_rdata > best_r) begin
          best_nxt = ram_rdata;
          bx_nxt   = cx_r;
          by_nxt   = cy_r;
        end
        cx_nxt = last_x ? '0 : cx_r + 1'b1;
        if (last_x) begin
          cy_nxt = cy_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.vote_value = best_r;
          out_data_nxt.cell_x     = bx_r;
          out_data_nxt.cell_y     = by_r;
          out_data_nxt.saturated  = sat_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cx_r        <= '0;
      cy_r        <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cols_cfg_r  <= SIZE_RESET;
      rows_cfg_r  <= SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_COLUMNS: cols_cfg_r <= cfg_wdata;
          REG_ROWS:    rows_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    gx_r       <= gx_nxt;
    gy_r       <= gy_nxt;
    p1_r       <= p1_nxt;
    dot_r      <= dot_nxt;
    d2_r       <= d2_nxt;
    num_r      <= num_nxt;
    q_r        <= q_nxt;
    best_r     <= best_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gcvm_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  gcvm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (num_r),
    .den  (d2_r),
    .done (div_done),
    .quo  (div_quo)
  );

endmodule
